@@ rtl/mif_pkg.sv @@
// Package: shared types and constants for the message-signalled interrupt file.
`default_nettype none
package mif_pkg;

  localparam int unsigned NumIdsDefault  = 255;
  localparam int unsigned WordBitsDefault = 64;

  // Operation codes
  localparam logic [2:0] OpRead    = 3'd0;
  localparam logic [2:0] OpWrite   = 3'd1;
  localparam logic [2:0] OpSet     = 3'd2;
  localparam logic [2:0] OpClear   = 3'd3;
  localparam logic [2:0] OpClaim   = 3'd4;
  localparam logic [2:0] OpMessage = 3'd5;

  // Indirect select map
  localparam logic [7:0] SelDelivery  = 8'h70;
  localparam logic [7:0] SelThreshold = 8'h72;
  localparam logic [7:0] SelPendBase  = 8'h80;
  localparam logic [7:0] SelPendLast  = 8'hBF;
  localparam logic [7:0] SelEnBase    = 8'hC0;
  localparam logic [7:0] SelEnLast    = 8'hFF;
  localparam int unsigned TopIdShift  = 16;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  select;
    logic [63:0] write_data;
    logic [7:0]  message_id;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [7:0]  claimed_id;
    logic        interrupt_line;
    logic        access_fault;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture the incoming transaction
    logic scan_clr;  // restart the top-identity scan
    logic scan_step; // examine one word
    logic exec;      // apply the access and build the result
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage
`default_nettype wire

@@ rtl/mif_datapath.sv @@
// Datapath: bit arrays, control registers, word-serial top-identity scan.
`default_nettype none
module mif_datapath #(
  parameter int unsigned NUM_IDS   = mif_pkg::NumIdsDefault,
  parameter int unsigned WORD_BITS = mif_pkg::WordBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire mif_pkg::req_t req_i,
  input  wire mif_pkg::cmd_t cmd_i,
  output mif_pkg::sts_t      sts_o,
  output mif_pkg::rsp_t      rsp_o
);
  import mif_pkg::*;

  localparam int unsigned NWords  = (NUM_IDS + WORD_BITS) / WORD_BITS;
  localparam int unsigned WIdxW   = (NWords > 1) ? $clog2(NWords) : 1;
  localparam int unsigned BitW    = $clog2(WORD_BITS);
  localparam int unsigned IdW     = $clog2(NWords * WORD_BITS);
  localparam int unsigned SelStep = WORD_BITS / 32;
  localparam int unsigned StepW   = (SelStep > 1) ? 1 : 0;
  localparam int unsigned CntW    = $clog2(NWords + 1);

  // Valid-bit mask of word w
  function automatic logic [WORD_BITS-1:0] valid_mask(input int unsigned w);
    logic [WORD_BITS-1:0] m;
    m = '0;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      if ((w * WORD_BITS + b) >= 1 && (w * WORD_BITS + b) <= NUM_IDS) m[b] = 1'b1;
    end
    return m;
  endfunction

  logic [WORD_BITS-1:0] pend_q [NWords];
  logic [WORD_BITS-1:0] en_q   [NWords];
  logic                 deliv_q;
  logic [7:0]           thr_q;
  req_t                 req_q;
  logic [CntW-1:0]      scan_q;
  logic                 found_q;
  logic [IdW-1:0]       top_q;
  rsp_t                 rsp_q;

  // Select decode
  logic [1:0]  kind;        // 0 fault, 1 delivery, 2 threshold, 3 word
  logic        is_en;
  logic [6:0]  koff;
  logic [6:0]  wsel;
  logic        wsel_ok;
  logic [WIdxW-1:0] widx;

  always_comb begin
    kind  = 2'd0;
    is_en = (req_q.select >= SelEnBase);
    koff  = is_en ? 7'(req_q.select - SelEnBase) : 7'(req_q.select - SelPendBase);
    wsel  = (SelStep > 1) ? (koff >> StepW) : koff;
    if (req_q.select == SelDelivery) kind = 2'd1;
    else if (req_q.select == SelThreshold) kind = 2'd2;
    else if (req_q.select >= SelPendBase) begin
      if (!((SelStep > 1) && koff[0])) kind = 2'd3;
    end
    wsel_ok = (32'(wsel) < NWords);
    widx    = WIdxW'(wsel);
  end

  // Old value of the addressed register
  logic [WORD_BITS-1:0] wmask;
  logic [63:0]          old_val;
  logic [63:0]          new_val;
  always_comb begin
    wmask   = '0;
    old_val = '0;
    for (int unsigned w = 0; w < NWords; w++) begin
      if (wsel_ok && widx == WIdxW'(w)) wmask = valid_mask(w);
    end
    case (kind)
      2'd1: old_val = 64'(deliv_q);
      2'd2: old_val = 64'(thr_q);
      2'd3: if (wsel_ok) old_val = 64'((is_en ? en_q[widx] : pend_q[widx]) & wmask);
      default: old_val = '0;
    endcase
    case (req_q.operation)
      OpWrite: new_val = req_q.write_data;
      OpSet:   new_val = old_val | req_q.write_data;
      OpClear: new_val = old_val & ~req_q.write_data;
      default: new_val = old_val;
    endcase
  end

  // Scan word: eligible bits of the current word under the threshold
  logic [WIdxW-1:0]     sidx;
  logic [WORD_BITS-1:0] elig;
  logic                 hit;
  logic [BitW-1:0]      hit_bit;
  always_comb begin
    sidx    = WIdxW'(scan_q);
    elig    = pend_q[sidx] & en_q[sidx];
    hit     = 1'b0;
    hit_bit = '0;
    for (int unsigned b = 0; b < WORD_BITS; b++) begin
      if (thr_q != 8'd0 && (32'(scan_q) * WORD_BITS + b) >= 32'(thr_q)) elig[b] = 1'b0;
    end
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (elig[b]) begin
        hit     = 1'b1;
        hit_bit = BitW'(b);
      end
    end
  end

  assign sts_o.scan_done = found_q || (32'(scan_q) >= NWords);

  // Scan registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q  <= '0;
      found_q <= 1'b0;
      top_q   <= '0;
    end else if (cmd_i.scan_clr) begin
      scan_q  <= '0;
      found_q <= 1'b0;
      top_q   <= '0;
    end else if (cmd_i.scan_step && !sts_o.scan_done) begin
      if (hit) begin
        found_q <= 1'b1;
        top_q   <= IdW'({sidx, hit_bit});
      end else begin
        scan_q <= scan_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= req_i;
  end

  // Top-identity fields
  logic [WIdxW-1:0] top_w;
  logic [BitW-1:0]  top_b;
  logic [WIdxW-1:0] msg_w;
  logic [BitW-1:0]  msg_b;
  logic             msg_ok;
  assign top_w  = WIdxW'(top_q >> BitW);
  assign top_b  = top_q[BitW-1:0];
  assign msg_w  = WIdxW'(req_q.message_id >> BitW);
  assign msg_b  = BitW'(req_q.message_id);
  assign msg_ok = (req_q.message_id != 8'd0) && (32'(req_q.message_id) <= NUM_IDS);

  // State update and result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned w = 0; w < NWords; w++) begin
        pend_q[w] <= '0;
        en_q[w]   <= '0;
      end
      deliv_q <= 1'b0;
      thr_q   <= '0;
    end else if (cmd_i.exec) begin
      case (req_q.operation)
        OpWrite, OpSet, OpClear: begin
          case (kind)
            2'd1: deliv_q <= new_val[0];
            2'd2: thr_q <= new_val[7:0];
            2'd3: begin
              if (wsel_ok) begin
                if (is_en) en_q[widx] <= WORD_BITS'(new_val) & wmask;
                else pend_q[widx] <= WORD_BITS'(new_val) & wmask;
              end
            end
            default: ;
          endcase
        end
        OpClaim: if (found_q) pend_q[top_w][top_b] <= 1'b0;
        OpMessage: if (msg_ok) pend_q[msg_w][msg_b] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      rsp_q.read_data      <= '0;
      rsp_q.claimed_id     <= '0;
      rsp_q.access_fault   <= 1'b0;
      rsp_q.interrupt_line <= 1'b0;
      case (req_q.operation)
        OpRead, OpWrite, OpSet, OpClear: begin
          rsp_q.read_data    <= old_val;
          rsp_q.access_fault <= (kind == 2'd0);
        end
        OpClaim: begin
          if (found_q) begin
            rsp_q.read_data  <= (64'(top_q) << TopIdShift) | 64'(top_q);
            rsp_q.claimed_id <= 8'(top_q);
          end
        end
        default: ;
      endcase
    end else if (cmd_i.scan_step && sts_o.scan_done) begin
      // Post-step rescan finished: interrupt line settles
      rsp_q.interrupt_line <= deliv_q && found_q;
    end
  end

  assign rsp_o = rsp_q;

endmodule
`default_nettype wire

@@ rtl/mif_ctrl.sv @@
// Controller: sequences load, scan, execute, rescan and output handshake.
`default_nettype none
module mif_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire mif_pkg::sts_t sts_i,
  output mif_pkg::cmd_t      cmd_o
);
  import mif_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StScan  = 3'd1;
  localparam logic [2:0] StExec  = 3'd2;
  localparam logic [2:0] StClr   = 3'd3;
  localparam logic [2:0] StRescan = 3'd4;
  localparam logic [2:0] StOut   = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load     = 1'b1;
          cmd_o.scan_clr = 1'b1;
          state_d        = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = StExec;
      end
      StExec: begin
        cmd_o.exec = 1'b1;
        state_d    = StClr;
      end
      StClr: begin
        cmd_o.scan_clr = 1'b1;
        state_d        = StRescan;
      end
      StRescan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) state_d = StOut;
      end
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StIdle;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

@@ rtl/msi_interrupt_file.sv @@
// Top level: message-signalled interrupt file with valid/ready channels.
`default_nettype none
// One interrupt file: pending and enable bits for identities 1..NUM_IDS, a
// delivery enable and a priority threshold, reached by indirect select.
// One transaction at a time, paced by the word-serial top-identity scan that
// runs once before the access and once after it to settle the interrupt line.
// Results are held in an output register until taken; the next transaction
// is accepted after that.
module msi_interrupt_file #(
  parameter int unsigned NUM_IDS   = mif_pkg::NumIdsDefault,
  parameter int unsigned WORD_BITS = mif_pkg::WordBitsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire mif_pkg::req_t in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output mif_pkg::rsp_t      out_data_o
);
  import mif_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mif_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  mif_datapath #(.NUM_IDS(NUM_IDS), .WORD_BITS(WORD_BITS)) u_dp (
    .clk_i, .rst_ni, .req_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .rsp_o(out_data_o)
  );

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input ready while result pending");
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");
  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.exec, cmd.scan_step, cmd.scan_clr}))
    else $error("conflicting datapath commands");
`endif

endmodule
`default_nettype wire
